// File: design/mtd_pkg.sv
// Shared types and constants for the Manchester edge timing decoder.
`timescale 1ns / 1ps

package mtd_pkg;

  localparam int unsigned TickW     = 16;
  localparam int unsigned HalfBitW  = 15;
  localparam int unsigned PreambleW = 8;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned BitPosW   = 3;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 15;

  // Twice the largest tick count and five half-bit periods both fit in 18 bits.
  localparam int unsigned CmpW = 18;

  localparam logic [HalfBitW-1:0]  HalfBitReset  = 15'd8000;
  localparam logic [PreambleW-1:0] PreambleReset = 8'd16;
  localparam logic [PreambleW-1:0] PreambleMax   = 8'd255;

  localparam logic [CfgIdxW-1:0] CfgHalfBit  = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgPreamble = 1'd1;

  typedef struct packed {
    logic [TickW-1:0] interval_ticks;
    logic             edge_rising;
  } mtd_in_t;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             last_byte;
  } mtd_out_t;

  typedef struct packed {
    logic short_hit;
    logic long_hit;
  } mtd_class_t;

  typedef struct packed {
    logic in_wait;
  } mtd_status_t;

endpackage

// File: design/mtd_classify.sv
// Interval classifier: sorts an edge interval into the 1T and 2T windows.
`timescale 1ns / 1ps

module mtd_classify
  import mtd_pkg::*;
(
  input  logic [TickW-1:0]    interval_i,
  input  logic [HalfBitW-1:0] half_bit_i,
  output mtd_class_t          class_o
);

  logic [CmpW-1:0] twice_t;
  logic [CmpW-1:0] one_t;
  logic [CmpW-1:0] three_t;
  logic [CmpW-1:0] five_t;

  assign twice_t = {{(CmpW-TickW-1){1'b0}}, interval_i, 1'b0};
  assign one_t   = {{(CmpW-HalfBitW){1'b0}}, half_bit_i};
  assign three_t = one_t + {one_t[CmpW-2:0], 1'b0};
  assign five_t  = one_t + {one_t[CmpW-3:0], 2'b00};

  assign class_o.short_hit = (twice_t > one_t) && (twice_t < three_t);
  assign class_o.long_hit  = (twice_t > three_t) && (twice_t < five_t);

endmodule

// File: design/mtd_core.sv
// Decoder state machine: preamble search, bit recovery and byte assembly.
`timescale 1ns / 1ps

module mtd_core
  import mtd_pkg::*;
#(
  parameter int unsigned PACKET_BYTES = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic                 edge_rising_i,
  input  mtd_class_t           class_i,
  input  logic [PreambleW-1:0] min_preamble_i,
  output logic                 res_valid_o,
  output mtd_out_t             res_o,
  output mtd_status_t          status_o
);

  localparam int unsigned BytePosW = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;
  localparam logic [BytePosW-1:0] LastBytePos = BytePosW'(PACKET_BYTES - 1);

  typedef enum logic [1:0] {
    ModeWait,
    ModeSync,
    ModeReceive,
    ModeReceiveShort
  } mode_e;

  mode_e                mode_q, mode_d;
  logic [PreambleW-1:0] preamble_q, preamble_d;
  logic                 prev_bit_q, prev_bit_d;
  logic [BitPosW-1:0]   bit_pos_q, bit_pos_d;
  logic [BytePosW-1:0]  byte_pos_q, byte_pos_d;
  logic [ByteW-1:0]     shift_q, shift_d;

  logic             store;
  logic             store_bit;
  logic [ByteW-1:0] shift_new;
  logic             byte_done;
  logic             packet_done;

  always_comb begin
    shift_new            = shift_q;
    shift_new[bit_pos_q] = store_bit;
  end

  assign byte_done   = store && (bit_pos_q == BitPosW'(ByteW - 1));
  assign packet_done = byte_done && (byte_pos_q == LastBytePos);

  always_comb begin
    mode_d     = mode_q;
    preamble_d = preamble_q;
    prev_bit_d = prev_bit_q;
    bit_pos_d  = bit_pos_q;
    byte_pos_d = byte_pos_q;
    shift_d    = shift_q;
    store      = 1'b0;
    store_bit  = prev_bit_q;
    if (step_i) begin
      unique case (mode_q)
        ModeWait: begin
          if (!edge_rising_i) begin
            mode_d     = ModeSync;
            preamble_d = '0;
            bit_pos_d  = '0;
            byte_pos_d = '0;
            shift_d    = '0;
          end
        end
        ModeSync: begin
          if (class_i.short_hit) begin
            if (preamble_q != PreambleMax) begin
              preamble_d = preamble_q + 1'b1;
            end
          end else if (class_i.long_hit) begin
            // A long interval before enough preamble leaves everything as it was.
            if (preamble_q > min_preamble_i) begin
              mode_d     = ModeReceive;
              prev_bit_d = 1'b0;
            end
          end else begin
            mode_d = ModeWait;
          end
        end
        ModeReceive: begin
          if (class_i.short_hit) begin
            mode_d = ModeReceiveShort;
          end else if (class_i.long_hit) begin
            prev_bit_d = !prev_bit_q;
            store_bit  = !prev_bit_q;
            store      = 1'b1;
          end else begin
            mode_d = ModeWait;
          end
        end
        ModeReceiveShort: begin
          if (class_i.short_hit) begin
            mode_d = ModeReceive;
            store  = 1'b1;
          end else begin
            mode_d = ModeWait;
          end
        end
        default: mode_d = ModeWait;
      endcase

      if (store) begin
        shift_d   = shift_new;
        bit_pos_d = bit_pos_q + 1'b1;
        if (byte_done) begin
          if (packet_done) begin
            byte_pos_d = '0;
            mode_d     = ModeWait;
          end else begin
            byte_pos_d = byte_pos_q + 1'b1;
          end
        end
      end
    end
  end

  assign res_valid_o     = byte_done;
  assign res_o.data_byte = shift_new;
  assign res_o.last_byte = packet_done;
  assign status_o.in_wait = (mode_q == ModeWait);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= ModeWait;
      preamble_q <= '0;
      prev_bit_q <= 1'b0;
      bit_pos_q  <= '0;
      byte_pos_q <= '0;
      shift_q    <= '0;
    end else begin
      mode_q     <= mode_d;
      preamble_q <= preamble_d;
      prev_bit_q <= prev_bit_d;
      bit_pos_q  <= bit_pos_d;
      byte_pos_q <= byte_pos_d;
      shift_q    <= shift_d;
    end
  end

endmodule

// File: design/manchester_edge_timing_decoder.sv
// Top level of the Manchester edge timing decoder.
//
// Usage: each input transfer carries one edge event, the timer ticks since
// the previous edge and the edge polarity. The decoder hunts for a preamble
// of 1T intervals closed by a 2T interval, then recovers bits and assembles
// bytes LSB first. Every finished byte leaves as one output transfer, and
// the last byte of a packet of PACKET_BYTES bytes carries last_byte.
// An accepted event waits in the input register until the output can take
// its byte. Throughput: one event per cycle while bytes are taken, set by
// the single input register feeding the classifier and state machine into
// the output register. Configuration: half_bit_ticks (index 0) and
// min_preamble (index 1) are written through the write port; the user must
// write them only while the decoder is idle; the block does not check.
// Reset returns the decoder to the wait state with both registers at their
// defaults. When the receiver stalls, the output holds its byte; one more
// event can sit in the input register, after which in_ready_o drops.
`timescale 1ns / 1ps

module manchester_edge_timing_decoder
  import mtd_pkg::*;
#(
  parameter int unsigned PACKET_BYTES = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mtd_in_t             in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mtd_out_t            out_item_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  logic [HalfBitW-1:0]  half_bit_q;
  logic [PreambleW-1:0] min_preamble_q;

  logic        s1_valid_q;
  mtd_in_t     s1_item_q;
  logic        out_valid_q;
  mtd_out_t    out_item_q;

  logic        step;
  mtd_class_t  iv_class;
  logic        res_valid;
  mtd_out_t    res;
  mtd_status_t status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_bit_q     <= HalfBitReset;
      min_preamble_q <= PreambleReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgHalfBit:  half_bit_q     <= cfg_wdata_i[HalfBitW-1:0];
        CfgPreamble: min_preamble_q <= cfg_wdata_i[PreambleW-1:0];
        default: ;
      endcase
    end
  end

  // The held event is decoded once the output register can take a byte.
  assign step       = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_item_q <= in_item_i;
    end
  end

  mtd_classify u_classify (
    .interval_i (s1_item_q.interval_ticks),
    .half_bit_i (half_bit_q),
    .class_o    (iv_class)
  );

  mtd_core #(
    .PACKET_BYTES (PACKET_BYTES)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .edge_rising_i  (s1_item_q.edge_rising),
    .class_i        (iv_class),
    .min_preamble_i (min_preamble_q),
    .res_valid_o    (res_valid),
    .res_o          (res),
    .status_o       (status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // The closing byte of a packet sends the decoder back to the wait state.
  a_last_to_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && res_valid && res.last_byte) |=> status.in_wait)
    else $error("decoder did not return to wait after the last byte");

  // Input back-pressure only comes from a held event behind a stalled output.
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled without a blocked output");

  // A new byte appears only from a decode step that produced one.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(step && res_valid))
    else $error("output became valid without a decoded byte");

endmodule

// File: verif/tb_manchester_edge_timing_decoder.sv
// Self-checking testbench for the Manchester edge timing decoder.
`timescale 1ns / 1ps

module tb_manchester_edge_timing_decoder;
  import mtd_pkg::*;

  localparam int unsigned PktBytes   = 8;
  localparam int unsigned ItemsTotal = 1925;

  typedef enum logic [1:0] {RxWait, RxSync, RxData, RxDataShort} rx_mode_e;
  typedef enum logic {RowEdge, RowCfg} row_kind_e;

  // One directed step: an edge event, or a register write made while idle.
  typedef struct packed {
    row_kind_e           kind;
    logic [15:0]         value;
    logic [CfgIdxW-1:0]  sel;
    logic                typed;
    logic                has_out;
    mtd_out_t            want;
  } step_row_t;

  localparam mtd_out_t NoByte = '0;

  localparam step_row_t DirRows [26] = '{
    '{RowEdge, 16'd65535, 1'b1, 1'b1, 1'b0, NoByte},
    '{RowEdge, 16'd0,     1'b0, 1'b1, 1'b0, NoByte},
    '{RowEdge, 16'd4001,  1'b1, 1'b1, 1'b0, NoByte},
    '{RowEdge, 16'd11999, 1'b0, 1'b1, 1'b0, NoByte},
    '{RowEdge, 16'd12001, 1'b1, 1'b1, 1'b0, NoByte},
    '{RowEdge, 16'd19999, 1'b0, 1'b1, 1'b0, NoByte},
    '{RowEdge, 16'd4000,  1'b1, 1'b1, 1'b0, NoByte},
    '{RowEdge, 16'd0,     1'b0, 1'b1, 1'b0, NoByte},
    '{RowEdge, 16'd12000, 1'b1, 1'b1, 1'b0, NoByte},
    '{RowEdge, 16'd20000, 1'b0, 1'b1, 1'b0, NoByte},
    '{RowEdge, 16'd20000, 1'b1, 1'b1, 1'b0, NoByte},
    '{RowCfg,  16'd0,     CfgPreamble, 1'b0, 1'b0, NoByte},
    '{RowEdge, 16'd65535, 1'b0, 1'b1, 1'b0, NoByte},
    '{RowEdge, 16'd8000,  1'b1, 1'b0, 1'b0, NoByte},
    '{RowEdge, 16'd16000, 1'b0, 1'b0, 1'b0, NoByte},
    '{RowEdge, 16'd16000, 1'b1, 1'b0, 1'b0, NoByte},
    '{RowEdge, 16'd16000, 1'b0, 1'b0, 1'b0, NoByte},
    '{RowEdge, 16'd16000, 1'b1, 1'b0, 1'b0, NoByte},
    '{RowEdge, 16'd16000, 1'b0, 1'b0, 1'b0, NoByte},
    '{RowEdge, 16'd16000, 1'b1, 1'b0, 1'b0, NoByte},
    '{RowEdge, 16'd16000, 1'b0, 1'b0, 1'b0, NoByte},
    '{RowEdge, 16'd16000, 1'b1, 1'b0, 1'b0, NoByte},
    '{RowEdge, 16'd16000, 1'b1, 1'b1, 1'b1, '{8'h55, 1'b0}},
    '{RowEdge, 16'd8000,  1'b0, 1'b0, 1'b0, NoByte},
    '{RowEdge, 16'd16000, 1'b1, 1'b1, 1'b0, NoByte},
    '{RowEdge, 16'd1,     1'b1, 1'b1, 1'b0, NoByte}
  };

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  mtd_in_t             in_item_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  mtd_out_t            out_item_o;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  // Shadow of the decoder: configuration and receive state.
  int unsigned  half_bit = HalfBitReset;
  logic [7:0]   pre_min  = PreambleReset;
  rx_mode_e     rx_mode  = RxWait;
  logic [7:0]   pre_cnt  = '0;
  logic         held_bit = 1'b0;
  logic [2:0]   bit_pos  = '0;
  int unsigned  byte_cnt = 0;
  logic [7:0]   shift_byte = '0;

  mtd_out_t     byte_q [$];
  int unsigned  failures = 0;
  int unsigned  sent = 0;
  bit           steady = 1'b0;
  int unsigned  ready_hold = 0;

  // Attributes of the transfer currently offered on the input side.
  bit           row_typed = 1'b0;
  bit           row_has_out = 1'b0;
  mtd_out_t     row_want = '0;

  manchester_edge_timing_decoder #(
    .PACKET_BYTES(PktBytes)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic bit is_1t(logic [15:0] ticks);
    int unsigned tw;
    tw = ticks;
    tw = tw * 2;
    return tw > half_bit && tw < 3 * half_bit;
  endfunction

  function automatic bit is_2t(logic [15:0] ticks);
    int unsigned tw;
    tw = ticks;
    tw = tw * 2;
    return tw > 3 * half_bit && tw < 5 * half_bit;
  endfunction

  function automatic bit shift_in_bit(logic b, output mtd_out_t res);
    shift_byte[bit_pos] = b;
    bit_pos = bit_pos + 3'd1;
    if (bit_pos != 3'd0) return 1'b0;
    byte_cnt++;
    res.data_byte = shift_byte;
    res.last_byte = 1'b0;
    if (byte_cnt >= PktBytes) begin
      res.last_byte = 1'b1;
      byte_cnt = 0;
      rx_mode = RxWait;
    end
    return 1'b1;
  endfunction

  // Advances the shadow state by one edge event; returns 1 when a byte completes.
  function automatic bit decode_edge(mtd_in_t ev, output mtd_out_t res);
    bit got;
    got = 1'b0;
    res = '0;
    case (rx_mode)
      RxWait: begin
        if (!ev.edge_rising) begin
          rx_mode = RxSync;
          pre_cnt = '0;
          bit_pos = '0;
          byte_cnt = 0;
          shift_byte = '0;
        end
      end
      RxSync: begin
        if (is_1t(ev.interval_ticks)) begin
          if (pre_cnt != PreambleMax) pre_cnt = pre_cnt + 8'd1;
        end else if (is_2t(ev.interval_ticks)) begin
          if (pre_cnt > pre_min) begin
            rx_mode = RxData;
            held_bit = 1'b0;
          end
        end else begin
          rx_mode = RxWait;
        end
      end
      RxData: begin
        if (is_1t(ev.interval_ticks)) begin
          rx_mode = RxDataShort;
        end else if (is_2t(ev.interval_ticks)) begin
          held_bit = ~held_bit;
          got = shift_in_bit(held_bit, res);
        end else begin
          rx_mode = RxWait;
        end
      end
      default: begin
        if (is_1t(ev.interval_ticks)) begin
          rx_mode = RxData;
          got = shift_in_bit(held_bit, res);
        end else begin
          rx_mode = RxWait;
        end
      end
    endcase
    return got;
  endfunction

  always @(posedge clk_i) begin : monitor
    mtd_out_t res;
    mtd_out_t want;
    bit got;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        got = decode_edge(in_item_i, res);
        if (row_typed) begin
          if (row_has_out) byte_q.push_back(row_want);
        end else if (got) begin
          byte_q.push_back(res);
        end
      end
      if (out_valid_o && out_ready_i) begin
        if (byte_q.size() == 0) begin
          $error("out_item: no byte expected, got data_byte %0h last_byte %0b",
                 out_item_o.data_byte, out_item_o.last_byte);
          failures++;
        end else begin
          want = byte_q.pop_front();
          if (out_item_o.data_byte !== want.data_byte) begin
            $error("data_byte: expected %0h, got %0h", want.data_byte, out_item_o.data_byte);
            failures++;
          end
          if (out_item_o.last_byte !== want.last_byte) begin
            $error("last_byte: expected %0b, got %0b", want.last_byte, out_item_o.last_byte);
            failures++;
          end
        end
      end
    end
  end

  // Receiver backpressure: mostly short stalls, now and then a long one.
  always @(negedge clk_i) begin : ready_gen
    int unsigned pick;
    if (steady) begin
      out_ready_i = 1'b1;
    end else if (ready_hold != 0) begin
      ready_hold--;
    end else begin
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        out_ready_i = 1'b1;
        ready_hold = $urandom_range(0, 12);
      end else if (pick < 9) begin
        out_ready_i = 1'b0;
        ready_hold = $urandom_range(0, 2);
      end else begin
        out_ready_i = 1'b0;
        ready_hold = $urandom_range(8, 30);
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [15:0] pick_between(int lo, int hi);
    if (hi > 65535) hi = 65535;
    if (lo < 0) lo = 0;
    if (lo > hi) return 16'($urandom_range(0, 65535));
    case ($urandom_range(0, 4))
      0: return 16'(lo);
      1: return 16'(hi);
      default: return 16'($urandom_range(lo, hi));
    endcase
  endfunction

  function automatic logic [15:0] pick_1t();
    int t;
    t = int'(half_bit);
    return pick_between(t / 2 + 1, (3 * t - 1) / 2);
  endfunction

  function automatic logic [15:0] pick_2t();
    int t;
    t = int'(half_bit);
    return pick_between((3 * t) / 2 + 1, (5 * t - 1) / 2);
  endfunction

  // An interval of neither class, often right on a class boundary.
  function automatic logic [15:0] pick_bad();
    int t;
    logic [15:0] cand;
    t = int'(half_bit);
    for (int k = 0; k < 16; k++) begin
      case ($urandom_range(0, 3))
        0: cand = 16'(t / 2);
        1: cand = 16'((3 * t) / 2);
        2: cand = 16'((5 * t) / 2);
        default: cand = 16'($urandom_range(0, 65535));
      endcase
      if (!is_1t(cand) && !is_2t(cand)) return cand;
    end
    return '0;
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_edge(input logic [15:0] ticks, input logic rising,
                           input bit typed = 1'b0, input bit has_out = 1'b0,
                           input mtd_out_t want = '0);
    int unsigned gap;
    @(negedge clk_i);
    in_valid_i = 1'b1;
    in_item_i.interval_ticks = ticks;
    in_item_i.edge_rising = rising;
    row_typed = typed;
    row_has_out = has_out;
    row_want = want;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // Holds the sender until every byte has left, then lets the pipeline empty.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (byte_q.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    if (idx == CfgHalfBit) half_bit = val;
    else pre_min = val[PreambleW-1:0];
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // One packet: resync, falling edge, preamble, sync, then data bits.
  // A broken packet is cut at a random bit by a bad interval or by a
  // single 1T interval that is followed by a 2T one.
  task automatic send_packet(input int unsigned pre_len, input bit broken);
    logic prev;
    logic [7:0] b;
    int unsigned cut;
    send_edge(16'd0, 1'b1);
    send_edge(16'($urandom_range(0, 65535)), 1'b0);
    repeat (pre_len) send_edge(pick_1t(), 1'($urandom_range(0, 1)));
    send_edge(pick_2t(), 1'($urandom_range(0, 1)));
    prev = 1'b0;
    b = '0;
    cut = broken ? $urandom_range(0, 8 * PktBytes - 1) : 8 * PktBytes;
    for (int i = 0; i < 8 * PktBytes; i++) begin
      if (i % 8 == 0) b = pick_byte();
      if (i == cut) begin
        if ($urandom_range(0, 1) == 0) begin
          send_edge(pick_bad(), 1'($urandom_range(0, 1)));
        end else begin
          send_edge(pick_1t(), 1'($urandom_range(0, 1)));
          send_edge(pick_2t(), 1'($urandom_range(0, 1)));
        end
        return;
      end
      if (b[i % 8] != prev) begin
        send_edge(pick_2t(), 1'($urandom_range(0, 1)));
      end else begin
        send_edge(pick_1t(), 1'($urandom_range(0, 1)));
        send_edge(pick_1t(), 1'($urandom_range(0, 1)));
      end
      prev = b[i % 8];
    end
  endtask

  initial begin : stimulus
    int unsigned phase;
    int unsigned stop;
    int unsigned r;
    int unsigned pre;
    logic [HalfBitW-1:0] new_t;
    logic [PreambleW-1:0] new_min;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (DirRows[i]) begin
      if (DirRows[i].kind == RowCfg) begin
        drain();
        write_reg(DirRows[i].sel, CfgDataW'(DirRows[i].value));
      end else begin
        send_edge(DirRows[i].value, DirRows[i].sel, DirRows[i].typed,
                  DirRows[i].has_out, DirRows[i].want);
      end
    end

    phase = 0;
    while (sent < ItemsTotal) begin
      drain();
      case (phase)
        0: begin new_t = 15'd2;     new_min = 8'd0;   end
        1: begin new_t = 15'd26214; new_min = 8'd255; end
        2: begin new_t = 15'd1;     new_min = 8'd3;   end
        3: begin new_t = 15'd0;     new_min = 8'd0;   end
        4: begin new_t = HalfBitReset; new_min = PreambleReset; end
        default: begin
          r = $urandom_range(0, 9);
          new_t = (r < 5) ? 15'($urandom_range(2, 200)) : 15'($urandom_range(2, 26214));
          r = $urandom_range(0, 9);
          if (r < 7) new_min = 8'($urandom_range(0, 8));
          else if (r < 9) new_min = 8'($urandom_range(9, 40));
          else new_min = 8'($urandom_range(200, 254));
        end
      endcase
      steady = (phase % 5 == 4);
      write_reg(CfgHalfBit, new_t);
      write_reg(CfgPreamble, {7'($urandom_range(0, 127)), new_min});

      if (half_bit == 0) begin
        // Both interval classes are empty here, so every event is noise.
        repeat (30) send_edge(16'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
      end else begin
        stop = sent + $urandom_range(150, 300);
        while (sent < stop && sent < ItemsTotal) begin
          r = $urandom_range(0, 99);
          if (r < 8) begin
            repeat ($urandom_range(1, 6))
              send_edge(16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
          end else begin
            case ($urandom_range(0, 19))
              0, 1: pre = pre_min;
              2: pre = $urandom_range(256, 270);
              default: pre = pre_min + 1 + $urandom_range(0, 3);
            endcase
            // A limit of 255 can never be exceeded, so sync is never reached.
            if (pre_min == PreambleMax) pre = 260;
            send_packet(pre, r < 25 || pre_min == PreambleMax);
          end
        end
      end
      phase++;
    end

    drain();
    if (failures == 0) begin
      $display("PASS manchester_edge_timing_decoder");
    end else begin
      $display("FAIL manchester_edge_timing_decoder");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("FAIL manchester_edge_timing_decoder");
    $finish;
  end

endmodule
